>>> hw/rtl/kled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kled_pkg;

   // Command codes carried on the request word
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_RECEIVE = 2'd2;

   // Keyboard protocol bytes
   localparam logic [7:0] BYTE_SET_LEDS = 8'hED;
   localparam logic [7:0] BYTE_ACK      = 8'hFA;
   localparam logic [7:0] BYTE_RESEND   = 8'hFE;
   localparam logic [7:0] BYTE_ESCAPE   = 8'h01;

   // Exchange status codes
   localparam logic [2:0] ST_NONE       = 3'd0;
   localparam logic [2:0] ST_OK         = 3'd1;
   localparam logic [2:0] ST_READY_TO   = 3'd2;
   localparam logic [2:0] ST_REPLY_TO   = 3'd3;
   localparam logic [2:0] ST_RETRIES    = 3'd4;
   localparam logic [2:0] ST_UNEXPECTED = 3'd5;
   localparam logic [2:0] ST_ESCAPE     = 3'd6;

   // Control register indexes
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_RETRIES = 1'b1;

   localparam logic [7:0] TIMEOUT_RESET = 8'd27;
   localparam logic [2:0] RETRIES_RESET = 3'd3;

   typedef struct packed {
      logic [7:0] timeout;
      logic [2:0] retries;
   } kled_cfg_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       key_valid;
      logic [7:0] key_code;
      logic       done;
      logic [2:0] status;
   } kled_result_type;

endpackage

`default_nettype wire

>>> hw/rtl/kled_step.sv
`timescale 1ns / 1ps
`default_nettype none

module kled_step #(
   parameter int TICK_COUNT_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      take,
   input  wire [1:0]                command,
   input  wire [2:0]                mask_bits,
   input  wire [7:0]                rx_byte,
   input  wire                      in_buf_full,
   input  kled_pkg::kled_cfg_type   cfg,
   output kled_pkg::kled_result_type result
);
   import kled_pkg::*;

   localparam int CMP_W = (TICK_COUNT_BITS > 8) ? TICK_COUNT_BITS : 8;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READY,
      PH_REPLY
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [2:0]                 mask_ff, mask_in;
   logic                       sending_mask_ff, sending_mask_in;
   logic [2:0]                 attempt_ff, attempt_in;
   logic [TICK_COUNT_BITS-1:0] tick_ff, tick_in;
   logic                       escape_ff, escape_in;
   logic                       awaiting_ff, awaiting_in;

   logic [TICK_COUNT_BITS-1:0] tick_inc;
   logic [7:0]                 limit;
   logic                       tick_expired;
   logic [2:0]                 attempt_inc;
   logic                       start_byte;
   logic                       send;
   logic                       finish;
   logic [2:0]                 finish_status;

   // Saturating tick count and timeout compare
   assign tick_inc     = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;
   assign limit        = (cfg.timeout == 8'd0) ? 8'd1 : cfg.timeout;
   assign tick_expired = CMP_W'(tick_inc) >= CMP_W'(limit);
   assign attempt_inc  = attempt_ff + 3'd1;

   // Next state and result word for one request word
   always_comb begin
      phase_in        = phase_ff;
      mask_in         = mask_ff;
      sending_mask_in = sending_mask_ff;
      attempt_in      = attempt_ff;
      tick_in         = tick_ff;
      escape_in       = escape_ff;
      awaiting_in     = awaiting_ff;
      result          = '0;
      start_byte      = 1'b0;
      send            = 1'b0;
      finish          = 1'b0;
      finish_status   = ST_NONE;

      case (command)
         CMD_START: begin
            if (phase_ff == PH_IDLE) begin
               mask_in         = mask_bits;
               sending_mask_in = 1'b0;
               attempt_in      = 3'd0;
               start_byte      = 1'b1;
            end
         end
         CMD_TICK: begin
            if (phase_ff == PH_READY) begin
               if (!in_buf_full) begin
                  send = 1'b1;
               end else begin
                  tick_in = tick_inc;
                  if (tick_expired) begin
                     finish        = 1'b1;
                     finish_status = ST_READY_TO;
                  end
               end
            end else if (phase_ff == PH_REPLY) begin
               if (escape_ff) begin
                  finish        = 1'b1;
                  finish_status = ST_ESCAPE;
               end else begin
                  tick_in = tick_inc;
                  if (tick_expired) begin
                     finish        = 1'b1;
                     finish_status = ST_REPLY_TO;
                  end
               end
            end
         end
         CMD_RECEIVE: begin
            if (awaiting_ff && phase_ff == PH_REPLY) begin
               awaiting_in = 1'b0;
               if (rx_byte == BYTE_RESEND) begin
                  attempt_in = attempt_inc;
                  if (attempt_inc < cfg.retries) begin
                     start_byte = 1'b1;
                  end else begin
                     finish        = 1'b1;
                     finish_status = ST_RETRIES;
                  end
               end else if (rx_byte == BYTE_ACK) begin
                  if (escape_ff) begin
                     finish        = 1'b1;
                     finish_status = ST_ESCAPE;
                  end else if (!sending_mask_ff) begin
                     sending_mask_in = 1'b1;
                     attempt_in      = 3'd0;
                     start_byte      = 1'b1;
                  end else begin
                     finish        = 1'b1;
                     finish_status = ST_OK;
                  end
               end else begin
                  finish        = 1'b1;
                  finish_status = ST_UNEXPECTED;
               end
            end else begin
               result.key_valid = 1'b1;
               result.key_code  = rx_byte;
               if (rx_byte == BYTE_ESCAPE) begin
                  escape_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // Begin a byte: wait for buffer, send at once if it is free
      if (start_byte) begin
         phase_in    = PH_READY;
         awaiting_in = 1'b0;
         tick_in     = '0;
         send        = !in_buf_full;
      end

      // Byte goes out; a pending escape aborts the reply wait
      if (send) begin
         result.tx_valid = 1'b1;
         result.tx_byte  = sending_mask_in ? {5'd0, mask_in} : BYTE_SET_LEDS;
         phase_in        = PH_REPLY;
         awaiting_in     = 1'b1;
         tick_in         = '0;
         if (escape_ff) begin
            finish        = 1'b1;
            finish_status = ST_ESCAPE;
         end
      end

      if (finish) begin
         phase_in      = PH_IDLE;
         awaiting_in   = 1'b0;
         tick_in       = '0;
         result.done   = 1'b1;
         result.status = finish_status;
      end
   end

   // Exchange state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         mask_ff         <= 3'd0;
         sending_mask_ff <= 1'b0;
         attempt_ff      <= 3'd0;
         tick_ff         <= '0;
         escape_ff       <= 1'b0;
         awaiting_ff     <= 1'b0;
      end else if (take) begin
         phase_ff        <= phase_in;
         mask_ff         <= mask_in;
         sending_mask_ff <= sending_mask_in;
         attempt_ff      <= attempt_in;
         tick_ff         <= tick_in;
         escape_ff       <= escape_in;
         awaiting_ff     <= awaiting_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/kled_out.sv
`timescale 1ns / 1ps
`default_nettype none

module kled_out (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       take,
   input  kled_pkg::kled_result_type result_in,
   input  wire                       rsp_stall,
   output logic                      rsp_valid,
   output kled_pkg::kled_result_type result,
   output logic                      full
);
   import kled_pkg::*;

   logic            valid_ff, valid_in;
   kled_result_type data_ff;

   // Held word blocks new requests only while the consumer stalls
   assign full      = valid_ff & rsp_stall;
   assign valid_in  = take | full;
   assign rsp_valid = valid_ff;
   assign result    = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/keyboard_led_command_sender.sv
// Output: a result word is on rsp_* in the cycle after its request word is taken.
// Throughput: one request word per cycle; only a stalled, held result word
//   stops intake, via req_stall.
// Reset (synchronous, active high): exchange idle, escape flag clear, output
//   register empty, timeout 27 ticks, retry limit 3.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_led_command_sender #(
   parameter int TICK_COUNT_BITS = 8
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [1:0]  req_command,
   input  wire [2:0]  req_leds,
   input  wire [7:0]  req_rx_byte,
   input  wire        req_in_buf_full,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_key_valid,
   output logic [7:0] rsp_key_code,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status,
   input  wire        csr_write_en,
   input  wire        csr_index,
   input  wire [7:0]  csr_wdata
);
   import kled_pkg::*;

   kled_cfg_type    cfg_ff, cfg_in;
   kled_result_type step_result;
   kled_result_type out_result;
   logic            take;
   logic            out_full;

   assign req_stall = out_full;
   assign take      = req_valid & ~out_full;

   // Control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_TIMEOUT: cfg_in.timeout = csr_wdata;
            CSR_RETRIES: cfg_in.retries = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout <= TIMEOUT_RESET;
         cfg_ff.retries <= RETRIES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kled_step #(
      .TICK_COUNT_BITS(TICK_COUNT_BITS)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .command     (req_command),
      .mask_bits   (req_leds),
      .rx_byte     (req_rx_byte),
      .in_buf_full (req_in_buf_full),
      .cfg         (cfg_ff),
      .result      (step_result)
   );

   kled_out u_out (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .result_in (step_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .result    (out_result),
      .full      (out_full)
   );

   assign rsp_tx_valid  = out_result.tx_valid;
   assign rsp_tx_byte   = out_result.tx_byte;
   assign rsp_key_valid = out_result.key_valid;
   assign rsp_key_code  = out_result.key_code;
   assign rsp_done_res  = out_result.done;
   assign rsp_status    = out_result.status;

endmodule

`default_nettype wire

>>> hw/rtl/kled_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kled_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire [1:0] req_command,
   input wire [7:0] req_rx_byte,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [7:0] rsp_tx_byte,
   input wire       rsp_key_valid,
   input wire [7:0] rsp_key_code,
   input wire [2:0] rsp_status
);
   import kled_pkg::*;

   // Every taken request yields a result word on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("taken request produced no result word");

   // Intake stops only behind a held, stalled result word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result word");

   // A key word echoes the received byte
   a_key_echo: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_RECEIVE) |=>
      (!rsp_key_valid || rsp_key_code == $past(req_rx_byte)))
      else $error("key code differs from the received byte");

   // Held result word stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_status)))
      else $error("stalled result word changed");

endmodule

bind keyboard_led_command_sender kled_checker u_kled_checker (.*);

`default_nettype wire
